// ===== rtl/core/ordered_value_list_engine_macros.svh =====
`ifndef ORDERED_VALUE_LIST_ENGINE_MACROS_SVH
`define ORDERED_VALUE_LIST_ENGINE_MACROS_SVH

// Overlapping implication, checked on every rising edge outside reset.
`define OVLE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define OVLE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ovle_pkg.sv =====
`default_nettype none

package ovle_pkg;

   localparam int OVLE_DEPTH   = 16;
   localparam int VALUE_W      = 32;
   localparam int COMMAND_W    = 3;
   localparam int STATUS_W     = 2;
   localparam int COUNT_W      = 5;
   localparam int REQ_TDATA_W  = 72;
   localparam int RSP_TDATA_W  = 112;

   typedef enum logic [COMMAND_W-1:0] {
      CMD_APPEND     = 3'd0,
      CMD_REMOVE     = 3'd1,
      CMD_REMOVE_ALL = 3'd2,
      CMD_COUNT      = 3'd3,
      CMD_REPLACE    = 3'd4,
      CMD_CLEAR      = 3'd5
   } ovle_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 2'd0,
      STS_NOT_FOUND = 2'd1,
      STS_FULL      = 2'd2,
      STS_EMPTY     = 2'd3
   } ovle_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } ovle_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic step;
      logic commit;
   } ovle_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic walk_done;
   } ovle_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/ovle_ram.sv =====
`default_nettype none

module ovle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/ovle_ctrl.sv =====
`default_nettype none

module ovle_ctrl import ovle_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output ovle_cmd_type       cmd,
   input  wire ovle_stat_type stat
);

   ovle_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // The result register may be reloaded once its current content is taken.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (stat.walk_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         ST_WALK: begin
            cmd.step = 1'b1;
         end
         ST_FINISH: begin
            cmd.commit = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ovle_dp.sv =====
`default_nettype none

module ovle_dp import ovle_pkg::*; #(
   parameter int DEPTH = OVLE_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ovle_cmd_type               cmd,
   output ovle_stat_type                   stat,
   input  wire logic        [COMMAND_W-1:0] in_command,
   input  wire logic signed [VALUE_W-1:0]   in_value,
   input  wire logic signed [VALUE_W-1:0]   in_new_value,
   output logic             [STATUS_W-1:0]  out_status,
   output logic signed      [VALUE_W-1:0]   out_removed_value,
   output logic             [COUNT_W-1:0]   out_match_count,
   output logic             [COUNT_W-1:0]   out_list_size,
   output logic signed      [VALUE_W-1:0]   out_head_value,
   output logic signed      [VALUE_W-1:0]   out_tail_value,
   output logic                             out_is_empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   logic        [COMMAND_W-1:0] op_ff, op_in;
   logic signed [VALUE_W-1:0]   val_ff, val_in;
   logic signed [VALUE_W-1:0]   nval_ff, nval_in;
   logic        [CW-1:0]        occ_ff, occ_in;
   logic        [CW-1:0]        rd_ff, rd_in;
   logic        [CW-1:0]        wr_ff, wr_in;
   logic        [CW-1:0]        cnt_ff, cnt_in;
   logic                        pend_ff, pend_in;
   logic                        found_ff, found_in;
   logic signed [VALUE_W-1:0]   head_ff, head_in;
   logic signed [VALUE_W-1:0]   tail_ff, tail_in;

   logic        [STATUS_W-1:0]  status_ff, status_in;
   logic signed [VALUE_W-1:0]   removed_ff, removed_in;
   logic        [COUNT_W-1:0]   mcount_ff, mcount_in;
   logic        [COUNT_W-1:0]   size_ff, size_in;
   logic signed [VALUE_W-1:0]   ohead_ff, ohead_in;
   logic signed [VALUE_W-1:0]   otail_ff, otail_in;
   logic                        oempty_ff, oempty_in;

   logic signed [VALUE_W-1:0]   rd_data;
   logic                        ram_we;
   logic        [AW-1:0]        ram_waddr;
   logic signed [VALUE_W-1:0]   ram_wdata;

   logic                        issue;
   logic                        hit, first_hit, keep, modifies, walk_we;
   logic signed [VALUE_W-1:0]   wdata;

   logic                        list_empty, list_full, app_we;
   logic        [STATUS_W-1:0]  status_c;
   logic        [CW-1:0]        occ_new;
   logic signed [VALUE_W-1:0]   head_c, tail_c;

   ovle_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ovle_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // One stored entry is read per cycle; its data returns in the next cycle and,
   // for remove, remove-all and replace, is written back, compacted, at the
   // write pointer, which never passes the read pointer.
   always_comb begin
      issue     = rd_ff < occ_ff;
      hit       = rd_data == val_ff;
      first_hit = hit && !found_ff;
      modifies  = 1'b0;
      keep      = 1'b1;
      wdata     = rd_data;
      unique case (op_ff)
         CMD_REMOVE: begin
            modifies = 1'b1;
            keep     = !first_hit;
         end
         CMD_REMOVE_ALL: begin
            modifies = 1'b1;
            keep     = !hit;
         end
         CMD_REPLACE: begin
            modifies = 1'b1;
            if (first_hit) begin
               wdata = nval_ff;
            end
         end
         default: begin
            modifies = 1'b0;
         end
      endcase
      walk_we        = cmd.step && pend_ff && keep && modifies;
      stat.walk_done = !pend_ff && (rd_ff == occ_ff);
   end

   always_comb begin
      list_empty = occ_ff == '0;
      list_full  = occ_ff == DEPTH_C;
      status_c   = STS_OK;
      occ_new    = occ_ff;
      head_c     = head_ff;
      tail_c     = tail_ff;
      removed_in = '0;
      app_we     = 1'b0;
      unique case (op_ff)
         CMD_APPEND: begin
            if (list_full) begin
               status_c = STS_FULL;
            end else begin
               app_we  = cmd.commit;
               occ_new = occ_ff + ONE_C;
               tail_c  = val_ff;
               if (list_empty) begin
                  head_c = val_ff;
               end
            end
         end
         CMD_REMOVE, CMD_REMOVE_ALL: begin
            occ_new = wr_ff;
            if (list_empty) begin
               status_c = STS_EMPTY;
            end else if (!found_ff) begin
               status_c = STS_NOT_FOUND;
            end else begin
               removed_in = val_ff;
            end
         end
         CMD_REPLACE: begin
            if (list_empty) begin
               status_c = STS_EMPTY;
            end else if (!found_ff) begin
               status_c = STS_NOT_FOUND;
            end
         end
         CMD_COUNT: begin
            if (list_empty) begin
               status_c = STS_EMPTY;
            end
         end
         CMD_CLEAR: begin
            occ_new = '0;
            if (list_empty) begin
               status_c = STS_EMPTY;
            end
         end
         default: begin
            status_c = STS_OK;
         end
      endcase
      if (occ_new == '0) begin
         head_c = '0;
         tail_c = '0;
      end
   end

   assign ram_we    = walk_we || app_we;
   assign ram_waddr = app_we ? occ_ff[AW-1:0] : wr_ff[AW-1:0];
   assign ram_wdata = app_we ? val_ff : wdata;

   assign status_in = status_c;
   assign mcount_in = COUNT_W'(cnt_ff);
   assign size_in   = COUNT_W'(occ_new);
   assign ohead_in  = head_c;
   assign otail_in  = tail_c;
   assign oempty_in = occ_new == '0;

   always_comb begin
      op_in    = op_ff;
      val_in   = val_ff;
      nval_in  = nval_ff;
      occ_in   = occ_ff;
      rd_in    = rd_ff;
      wr_in    = wr_ff;
      cnt_in   = cnt_ff;
      pend_in  = 1'b0;
      found_in = found_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      priority if (cmd.start) begin
         op_in    = in_command;
         val_in   = in_value;
         nval_in  = in_new_value;
         rd_in    = '0;
         wr_in    = '0;
         cnt_in   = '0;
         found_in = 1'b0;
         head_in  = '0;
         tail_in  = '0;
      end else if (cmd.step) begin
         pend_in = issue;
         if (issue) begin
            rd_in = rd_ff + ONE_C;
         end
         if (pend_ff) begin
            found_in = found_ff || hit;
            if (hit) begin
               cnt_in = cnt_ff + ONE_C;
            end
            if (keep) begin
               wr_in   = wr_ff + ONE_C;
               tail_in = wdata;
               if (wr_ff == '0) begin
                  head_in = wdata;
               end
            end
         end
      end else if (cmd.commit) begin
         occ_in = occ_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         occ_ff  <= occ_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      val_ff   <= val_in;
      nval_ff  <= nval_in;
      rd_ff    <= rd_in;
      wr_ff    <= wr_in;
      cnt_ff   <= cnt_in;
      found_ff <= found_in;
      head_ff  <= head_in;
      tail_ff  <= tail_in;
      if (cmd.commit) begin
         status_ff  <= status_in;
         removed_ff <= removed_in;
         mcount_ff  <= mcount_in;
         size_ff    <= size_in;
         ohead_ff   <= ohead_in;
         otail_ff   <= otail_in;
         oempty_ff  <= oempty_in;
      end
   end

   assign out_status        = status_ff;
   assign out_removed_value = removed_ff;
   assign out_match_count   = mcount_ff;
   assign out_list_size     = size_ff;
   assign out_head_value    = ohead_ff;
   assign out_tail_value    = otail_ff;
   assign out_is_empty      = oempty_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ordered_value_list_engine.sv =====
// Channel   Direction  Ports                     Contents
// request   in         req_tvalid/tready/tdata   command, value, new_value
// response  out        rsp_tvalid/tready/tdata   status, removed_value, counts, head, tail
//
// A request passes through the walk and finish states from acceptance to its
// response; the walk reads one stored entry per cycle from a single RAM read
// port and compares it against the request value.
// One request is worked on at a time; a new one is accepted while the previous
// response still waits in its output register.
// Reset is synchronous and empties the list; the stored entries are not cleared.
`default_nettype none

module ordered_value_list_engine import ovle_pkg::*; #(
   parameter int DEPTH = OVLE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [2:0] command, [34:3] value, [66:35] new_value, rest zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [1:0] status, [33:2] removed_value, [38:34] match_count, [43:39] list_size,
   // [75:44] head_value, [107:76] tail_value, [108] is_empty, rest zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   ovle_cmd_type               cmd;
   ovle_stat_type              stat;
   logic        [STATUS_W-1:0] status;
   logic signed [VALUE_W-1:0]  removed_value;
   logic        [COUNT_W-1:0]  match_count;
   logic        [COUNT_W-1:0]  list_size;
   logic signed [VALUE_W-1:0]  head_value;
   logic signed [VALUE_W-1:0]  tail_value;
   logic                       is_empty;

   ovle_ctrl u_ovle_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   ovle_dp #(
      .DEPTH (DEPTH)
   ) u_ovle_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .in_command        (req_tdata[2:0]),
      .in_value          (req_tdata[34:3]),
      .in_new_value      (req_tdata[66:35]),
      .out_status        (status),
      .out_removed_value (removed_value),
      .out_match_count   (match_count),
      .out_list_size     (list_size),
      .out_head_value    (head_value),
      .out_tail_value    (tail_value),
      .out_is_empty      (is_empty)
   );

   assign rsp_tdata = {3'b000, is_empty, tail_value, head_value, list_size,
                       match_count, removed_value, status};

endmodule

`default_nettype wire

// ===== rtl/core/ovle_checker.sv =====
`default_nettype none
`include "ordered_value_list_engine_macros.svh"

module ovle_checker import ovle_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic [REQ_TDATA_W-1:0] req_tdata,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0]  rsp_removed;
   logic [COUNT_W-1:0]  rsp_size;
   logic [VALUE_W-1:0]  rsp_head;
   logic [VALUE_W-1:0]  rsp_tail;
   logic                rsp_empty;
   logic                req_pad_unused;

   assign rsp_status     = rsp_tdata[1:0];
   assign rsp_removed    = rsp_tdata[33:2];
   assign rsp_size       = rsp_tdata[43:39];
   assign rsp_head       = rsp_tdata[75:44];
   assign rsp_tail       = rsp_tdata[107:76];
   assign rsp_empty      = rsp_tdata[108];
   assign req_pad_unused = ^req_tdata;

   // No response may be left over from before a reset.
   `OVLE_ASSERT_IMP(a_no_rsp_after_reset, clock, reset, $past(reset), !rsp_tvalid, "response valid right after reset")

   // A request is worked on alone, so the port closes straight after acceptance.
   `OVLE_ASSERT_NXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "request accepted while another is in flight")

   // An empty list reports zero size and zero head and tail.
   `OVLE_ASSERT_IMP(a_empty_fields, clock, reset, rsp_tvalid && rsp_empty, rsp_size == '0 && rsp_head == '0 && rsp_tail == '0 && !req_pad_unused || rsp_size == '0 && rsp_head == '0 && rsp_tail == '0, "empty list with nonzero size, head or tail")

   // Something is only removed by a successful command.
   `OVLE_ASSERT_IMP(a_removed_ok, clock, reset, rsp_tvalid && rsp_removed != '0, rsp_status == STS_OK, "removed value with a failing status")

   `OVLE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

endmodule

bind ordered_value_list_engine ovle_checker u_ovle_checker (.*);

`default_nettype wire

// ===== tb/sv/ordered_value_list_engine_check.sv =====
`timescale 1ns / 1ps

module ordered_value_list_engine_check import ovle_pkg::*; #(
   parameter int DEPTH = OVLE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   // [2:0] command, [34:3] value, [66:35] new_value, rest zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [1:0] status, [33:2] removed_value, [38:34] match_count, [43:39] list_size,
   // [75:44] head_value, [107:76] tail_value, [108] is_empty, rest zero
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                          mismatch_count,
   output int                          responses_due
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  removed_value;
      logic [COUNT_W-1:0]  match_count;
      logic [COUNT_W-1:0]  list_size;
      logic [VALUE_W-1:0]  head_value;
      logic [VALUE_W-1:0]  tail_value;
      logic                is_empty;
   } list_result_type;

   logic [VALUE_W-1:0] list_entries [DEPTH];
   int                 list_fill;
   list_result_type    pending_responses [$];
   int                 mismatch_total;

   assign mismatch_count = mismatch_total;

   // Applies one request to the shadow list and works out the response it must give.
   task automatic predict_list_result(input logic [COMMAND_W-1:0] op,
                                      input logic [VALUE_W-1:0] val,
                                      input logic [VALUE_W-1:0] nval,
                                      output list_result_type res);
      int match_total;
      int first_pos;
      int kept;
      logic was_empty;
      match_total = 0;
      first_pos   = -1;
      was_empty   = (list_fill == 0);
      for (int i = 0; i < list_fill; i++) begin
         if (list_entries[i] == val) begin
            if (first_pos < 0) first_pos = i;
            match_total++;
         end
      end
      res               = '0;
      res.status        = STS_OK;
      res.match_count   = match_total[COUNT_W-1:0];
      case (op)
         CMD_APPEND: begin
            if (list_fill >= DEPTH) begin
               res.status = STS_FULL;
            end else begin
               list_entries[list_fill] = val;
               list_fill++;
            end
         end
         CMD_REMOVE: begin
            if (was_empty) begin
               res.status = STS_EMPTY;
            end else if (first_pos >= 0) begin
               for (int i = first_pos; i + 1 < list_fill; i++)
                  list_entries[i] = list_entries[i + 1];
               list_fill--;
               res.removed_value = val;
            end else begin
               res.status = STS_NOT_FOUND;
            end
         end
         CMD_REMOVE_ALL: begin
            if (was_empty) begin
               res.status = STS_EMPTY;
            end else if (match_total == 0) begin
               res.status = STS_NOT_FOUND;
            end else begin
               kept = 0;
               for (int i = 0; i < list_fill; i++) begin
                  if (list_entries[i] != val) begin
                     list_entries[kept] = list_entries[i];
                     kept++;
                  end
               end
               list_fill         = kept;
               res.removed_value = val;
            end
         end
         CMD_COUNT: begin
            if (was_empty) res.status = STS_EMPTY;
         end
         CMD_REPLACE: begin
            if (was_empty) begin
               res.status = STS_EMPTY;
            end else if (first_pos >= 0) begin
               list_entries[first_pos] = nval;
            end else begin
               res.status = STS_NOT_FOUND;
            end
         end
         CMD_CLEAR: begin
            if (was_empty) res.status = STS_EMPTY;
            list_fill = 0;
         end
         default: begin
            // The two spare codes leave the list alone and report success.
         end
      endcase
      res.list_size = list_fill[COUNT_W-1:0];
      if (list_fill == 0) begin
         res.is_empty = 1'b1;
      end else begin
         res.head_value = list_entries[0];
         res.tail_value = list_entries[list_fill - 1];
      end
   endtask

   task automatic check_field(input string name, input logic [VALUE_W-1:0] want_v,
                              input logic [VALUE_W-1:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         mismatch_total++;
      end
   endtask

   always @(posedge clock) begin
      list_result_type got;
      list_result_type want;
      if (reset) begin
         list_fill = 0;
         pending_responses.delete();
         responses_due <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status        = rsp_tdata[1:0];
            got.removed_value = rsp_tdata[33:2];
            got.match_count   = rsp_tdata[38:34];
            got.list_size     = rsp_tdata[43:39];
            got.head_value    = rsp_tdata[75:44];
            got.tail_value    = rsp_tdata[107:76];
            got.is_empty      = rsp_tdata[108];
            if (pending_responses.size() == 0) begin
               $error("response arrived with no request outstanding");
               mismatch_total++;
            end else begin
               want = pending_responses.pop_front();
               check_field("status", want.status, got.status);
               check_field("removed_value", want.removed_value, got.removed_value);
               check_field("match_count", want.match_count, got.match_count);
               check_field("list_size", want.list_size, got.list_size);
               check_field("head_value", want.head_value, got.head_value);
               check_field("tail_value", want.tail_value, got.tail_value);
               check_field("is_empty", want.is_empty, got.is_empty);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_list_result(req_tdata[2:0], req_tdata[34:3], req_tdata[66:35], want);
            pending_responses.push_back(want);
         end
         responses_due <= pending_responses.size();
      end
   end

endmodule

// ===== tb/sv/ordered_value_list_engine_test.sv =====
`timescale 1ns / 1ps

module ordered_value_list_engine_test;
   import ovle_pkg::*;

   localparam int DEPTH = OVLE_DEPTH;
   localparam int ITEMS_PER_PHASE = 350;

   // Codes six and seven have no operation behind them.
   localparam logic [COMMAND_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [COMMAND_W-1:0] CMD_SPARE_HI = 3'd7;

   localparam logic [VALUE_W-1:0] VAL_MIN       = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] VAL_MAX       = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] VAL_ZERO      = 32'h0000_0000;
   localparam logic [VALUE_W-1:0] VAL_MINUS_ONE = 32'hFFFF_FFFF;
   localparam logic [VALUE_W-1:0] VAL_ABSENT    = 32'h0000_0005;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   wire logic              req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   wire logic              rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   wire logic [RSP_TDATA_W-1:0] rsp_tdata;
   int                     mismatch_count;
   int                     responses_due;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int items_sent         = 0;

   ordered_value_list_engine #(.DEPTH(DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ordered_value_list_engine_check #(.DEPTH(DEPTH)) u_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .responses_due  (responses_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   task automatic send_request(input logic [COMMAND_W-1:0] op, input logic [VALUE_W-1:0] val,
                               input logic [VALUE_W-1:0] nval);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {5'd0, nval, val, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Holds the request channel quiet until every outstanding response has come back.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (responses_due != 0) @(posedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value(input logic [VALUE_W-1:0] pool [4],
                                                     input int pool_pct);
      if ($urandom_range(99) < pool_pct) return pool[$urandom_range(3)];
      return $urandom();
   endfunction

   // One run of appends that tends to fill the list, followed by mixed commands on its contents.
   task automatic run_list_episode();
      logic [VALUE_W-1:0] pool [4];
      logic [VALUE_W-1:0] corners [4];
      logic [COMMAND_W-1:0] op;
      int fill_len;
      int mix_len;
      int pick;
      corners = '{VAL_MIN, VAL_MAX, VAL_ZERO, VAL_MINUS_ONE};
      for (int i = 0; i < 4; i++)
         pool[i] = ($urandom_range(3) == 0) ? corners[$urandom_range(3)] : $urandom();
      fill_len = $urandom_range(20);
      mix_len  = $urandom_range(20, 5);
      for (int i = 0; i < fill_len; i++)
         send_request(CMD_APPEND, pick_value(pool, 90), $urandom());
      for (int i = 0; i < mix_len; i++) begin
         pick = $urandom_range(99);
         if (pick < 25)      op = CMD_APPEND;
         else if (pick < 42) op = CMD_REMOVE;
         else if (pick < 52) op = CMD_REMOVE_ALL;
         else if (pick < 66) op = CMD_COUNT;
         else if (pick < 84) op = CMD_REPLACE;
         else if (pick < 88) op = CMD_CLEAR;
         else if (pick < 92) op = ($urandom_range(1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
         else                op = COMMAND_W'($urandom_range(7));
         send_request(op, pick_value(pool, 80), pick_value(pool, 50));
      end
   endtask

   initial begin
      logic [VALUE_W-1:0] fill_vals [4];
      int phase_start;
      fill_vals = '{VAL_MIN, VAL_MAX, VAL_ZERO, VAL_MINUS_ONE};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every command that needs an entry, issued on the empty list, then the list filled, overflowed and probed.
      send_request(CMD_REMOVE, VAL_MIN, VAL_ZERO);
      send_request(CMD_REMOVE_ALL, VAL_MAX, VAL_ZERO);
      send_request(CMD_COUNT, VAL_ZERO, VAL_ZERO);
      send_request(CMD_REPLACE, VAL_MINUS_ONE, VAL_ZERO);
      send_request(CMD_CLEAR, VAL_ZERO, VAL_ZERO);
      for (int i = 0; i < DEPTH; i++)
         send_request(CMD_APPEND, fill_vals[i % 4], VAL_ZERO);
      send_request(CMD_APPEND, VAL_ABSENT, VAL_ZERO);
      send_request(CMD_COUNT, VAL_MINUS_ONE, VAL_ZERO);
      send_request(CMD_REMOVE, VAL_ABSENT, VAL_ZERO);
      send_request(CMD_REMOVE_ALL, VAL_ABSENT, VAL_ZERO);
      send_request(CMD_REPLACE, VAL_ABSENT, VAL_MAX);
      send_request(CMD_REMOVE, VAL_MIN, VAL_ZERO);
      send_request(CMD_REMOVE_ALL, VAL_MAX, VAL_ZERO);
      send_request(CMD_REPLACE, VAL_ZERO, VAL_MAX);
      send_request(CMD_SPARE_LO, VAL_MINUS_ONE, VAL_MIN);
      send_request(CMD_SPARE_HI, VAL_MAX, VAL_MINUS_ONE);
      send_request(CMD_CLEAR, VAL_ZERO, VAL_ZERO);

      for (int phase = 0; phase < 4; phase++) begin
         drain_responses();
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 54; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 54; end
            default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < ITEMS_PER_PHASE) run_list_episode();
      end

      drain_responses();
      repeat (DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
